// File: rtl/lph_pkg.sv
`default_nettype none

package lph_pkg;

   localparam int KEY_W    = 64;
   localparam int HASH_W   = 32;
   localparam int LEN_W    = 4;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 10;
   localparam int CSR_W    = 4;

   localparam logic [CSR_W-1:0] INDEX_BITS_RESET = 4'd10;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   typedef struct packed {
      logic               used;
      logic [HASH_W-1:0]  hash;
      logic [KEY_W-1:0]   key;
      logic [LEN_W-1:0]   len;
      logic [VALUE_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value;
      logic [SLOT_W-1:0]   slot;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/linear_probe_hash_table_core.sv
// flow: each probed slot is read in turn, and the response is registered once a probe
//   ends the search; a zero-payload insert answers FULL without probing
// throughput: one request at a time, req_stall staying high until its response is
//   registered; the single table read port reads one slot per cycle; an insert writes
//   its slot in its last probe cycle
// reset: synchronous; a clearing pass marks every slot empty while req_stall stays high;
//   index_bits returns to 10, csr writes are taken whenever reset is low
`default_nettype none

module linear_probe_hash_table_core #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [lph_pkg::CSR_W-1:0]   csr_wr_data,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_mode,
   input  wire logic [lph_pkg::HASH_W-1:0]  req_key_hash,
   input  wire logic [lph_pkg::KEY_W-1:0]   req_key_bytes,
   input  wire logic [lph_pkg::LEN_W-1:0]   req_key_length,
   input  wire logic [lph_pkg::VALUE_W-1:0] req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [lph_pkg::STATUS_W-1:0]     rsp_status,
   output logic [lph_pkg::VALUE_W-1:0]      rsp_found_value,
   output logic [lph_pkg::SLOT_W-1:0]       rsp_slot_index
);

   import lph_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   // largest k with 2^k - 1 below the depth
   localparam int MAX_BITS = $clog2(TABLE_DEPTH + 1) - 1;

   logic [CSR_W-1:0] index_bits_ff, index_bits_in;
   logic [4:0]       eff_bits;
   logic [IDX_W-1:0] mask;

   result_type       rsp;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   entry_type        mem_wr_data;
   logic [IDX_W-1:0] mem_rd_addr;
   entry_type        mem_rd_data;

   assign index_bits_in = csr_wr_en ? csr_wr_data : index_bits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff <= INDEX_BITS_RESET;
      end else begin
         index_bits_ff <= index_bits_in;
      end
   end

   always_comb begin
      eff_bits = {1'b0, index_bits_ff};
      if (eff_bits == 5'd0) begin
         eff_bits = 5'd1;
      end
      if (eff_bits > 5'(MAX_BITS)) begin
         eff_bits = 5'(MAX_BITS);
      end
   end

   assign mask = ~({IDX_W{1'b1}} << eff_bits);

   lph_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lph_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .mask           (mask),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_key_hash   (req_key_hash),
      .req_key_bytes  (req_key_bytes),
      .req_key_length (req_key_length),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp            (rsp),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_wr_data    (mem_wr_data),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data)
   );

   assign rsp_status      = rsp.status;
   assign rsp_found_value = rsp.value;
   assign rsp_slot_index  = rsp.slot;

endmodule

`default_nettype wire

// File: rtl/lph_ram.sv
`default_nettype none

module lph_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lph_engine.sv
`default_nettype none

module lph_engine #(
   parameter int TABLE_DEPTH = 1024,
   parameter int KEY_BYTES   = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] mask,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_mode,
   input  wire logic [lph_pkg::HASH_W-1:0]     req_key_hash,
   input  wire logic [lph_pkg::KEY_W-1:0]      req_key_bytes,
   input  wire logic [lph_pkg::LEN_W-1:0]      req_key_length,
   input  wire logic [lph_pkg::VALUE_W-1:0]    req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output lph_pkg::result_type                 rsp,
   output logic                                mem_wr_en,
   output logic      [$clog2(TABLE_DEPTH)-1:0] mem_wr_addr,
   output lph_pkg::entry_type                  mem_wr_data,
   output logic      [$clog2(TABLE_DEPTH)-1:0] mem_rd_addr,
   input  wire lph_pkg::entry_type             mem_rd_data
);

   import lph_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_PROBE = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic                 mode_ff, mode_in;
   logic [HASH_W-1:0]    hash_ff, hash_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [VALUE_W-1:0]   payload_ff, payload_in;
   logic [IDX_W-1:0]     mask_ff, mask_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic [IDX_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     clr_ff, clr_in;
   result_type           pend_ff, pend_in;
   result_type           rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [LEN_W-1:0]     len_sat;
   logic [KEY_W-1:0]     key_clean;
   logic [IDX_W-1:0]     start_slot;
   logic [IDX_W-1:0]     next_slot;
   logic                 out_free;
   logic                 hit;
   logic                 done;
   result_type           res;

   // key bytes past the length are dropped so stored and compared keys agree
   always_comb begin
      len_sat = (req_key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req_key_length;
      for (int i = 0; i < KEY_W / 8; i++) begin
         key_clean[8*i +: 8] = (LEN_W'(i) < len_sat) ? req_key_bytes[8*i +: 8] : 8'h00;
      end
   end

   assign start_slot = (req_key_hash[IDX_W-1:0] + IDX_W'(1)) & mask;
   assign next_slot  = (slot_ff + IDX_W'(1)) & mask_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign hit = mem_rd_data.used && (mem_rd_data.hash == hash_ff) &&
                (mem_rd_data.len == len_ff) && (mem_rd_data.key == key_ff);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      hash_in      = hash_ff;
      key_in       = key_ff;
      len_in       = len_ff;
      payload_in   = payload_ff;
      mask_in      = mask_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = slot_ff;
      mem_wr_data  = '0;
      mem_rd_addr  = slot_ff;
      done         = 1'b0;
      res          = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // one slot per cycle marked empty after reset
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            clr_in      = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            mem_rd_addr = start_slot;
            if (req_valid) begin
               mode_in    = req_mode;
               hash_in    = req_key_hash;
               key_in     = key_clean;
               len_in     = len_sat;
               payload_in = req_payload;
               mask_in    = mask;
               slot_in    = start_slot;
               count_in   = '0;
               if (req_mode == MODE_INSERT && req_payload == '0) begin
                  pend_in  = '{status: STATUS_FULL, value: '0, slot: '0};
                  state_in = ST_HOLD;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            mem_rd_addr = next_slot;
            if (!mem_rd_data.used) begin
               done = 1'b1;
               if (mode_ff == MODE_INSERT) begin
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = slot_ff;
                  mem_wr_data = '{used: 1'b1, hash: hash_ff, key: key_ff,
                                  len: len_ff, value: payload_ff};
                  res = '{status: STATUS_INSERTED, value: '0, slot: SLOT_W'(slot_ff)};
               end else begin
                  res = '{status: STATUS_NOT_FOUND, value: '0, slot: '0};
               end
            end else if (mode_ff == MODE_LOOKUP && hit) begin
               done = 1'b1;
               res  = '{status: STATUS_FOUND, value: mem_rd_data.value,
                        slot: SLOT_W'(slot_ff)};
            end else if (count_ff == mask_ff) begin
               // every slot under the mask has been probed once
               done = 1'b1;
               res  = '{status: STATUS_FULL, value: '0, slot: '0};
            end else begin
               slot_in  = next_slot;
               count_in = count_ff + IDX_W'(1);
            end
            if (done) begin
               if (out_free) begin
                  rsp_in       = res;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  pend_in  = res;
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      hash_ff    <= hash_in;
      key_ff     <= key_in;
      len_ff     <= len_in;
      payload_ff <= payload_in;
      mask_ff    <= mask_in;
      slot_ff    <= slot_in;
      count_ff   <= count_in;
      pend_ff    <= pend_in;
      rsp_ff     <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/lph_checker.sv
`default_nettype none

module lph_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_stall,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [lph_pkg::STATUS_W-1:0] rsp_status,
   input wire logic [lph_pkg::VALUE_W-1:0]  rsp_found_value,
   input wire logic [lph_pkg::SLOT_W-1:0]   rsp_slot_index
);

   import lph_pkg::*;

   // table is being cleared right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during clearing pass");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   // stored payloads are never zero
   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FOUND |-> rsp_found_value != '0)
      else $error("found response with zero value");

   a_value_only_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_FOUND |-> rsp_found_value == '0)
      else $error("value reported on a miss");

   a_slot_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOT_FOUND || rsp_status == STATUS_FULL)
      |-> rsp_slot_index == '0)
      else $error("slot reported on a miss");

endmodule

bind linear_probe_hash_table_core lph_checker u_checker (.*);

`default_nettype wire
